// File: hw/rtl/assert_macros.svh
// assertion macros for the rtl files, included by tkfh_dp.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define AST_HOLD(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define AST_SAME(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`define AST_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define AST_HOLD(name, clk, rst_n, expr)
`define AST_SAME(name, clk, rst_n, pre, post)
`define AST_NEXT(name, clk, rst_n, pre, post)

`endif

`endif

// File: hw/rtl/tkfh_pkg.sv
// shared types and constants of the top-k frequency heap
`default_nettype none

package tkfh_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int KW    = AW + 2;

    localparam logic [4:0] CAP_RESET = 5'd16;

    typedef enum logic [2:0] {
        ST_INSERTED   = 3'd0,
        ST_REPLACED   = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_READ_OK    = 3'd3,
        ST_READ_EMPTY = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_RD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] freq;
    } entry_t;

    typedef struct packed {
        logic    load;
        logic    grow;
        logic    up_rd;
        logic    up_step;
        logic    dn_rd;
        logic    dn_step;
        logic    wr_item;
        logic    rd_slot;
        logic    finish;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic is_read;
        logic rd_ok;
        logic ins_free;
        logic ins_repl;
        logic up_top;
        logic up_move;
        logic dn_move;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/top_k_frequency_heap.sv
// top level of the top-k frequency heap: controller plus datapath
// a read fetches the slot and reports it; a drop only reports; an insert sifts the
//   new entry up and a replace sifts it down, one heap level per read and compare step
// throughput: one transaction at a time; busy stays high until the result strobe
// reset: heap empty, capacity 16; the receiver cannot stall the result
`default_nettype none

module top_k_frequency_heap (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        action,
    input  wire logic [15:0] word_tag,
    input  wire logic [31:0] frequency,
    input  wire logic [3:0]  slot_index,
    output logic             done,
    output logic [2:0]       status,
    output logic [4:0]       entry_count,
    output logic [15:0]      read_tag,
    output logic [31:0]      read_frequency,
    output logic [31:0]      min_frequency,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);
    import tkfh_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t st;

    tkfh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .cmd   (cmd)
    );

    tkfh_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .action         (action),
        .word_tag       (word_tag),
        .frequency      (frequency),
        .slot_index     (slot_index),
        .done           (done),
        .status         (status),
        .entry_count    (entry_count),
        .read_tag       (read_tag),
        .read_frequency (read_frequency),
        .min_frequency  (min_frequency)
    );

endmodule

`default_nettype wire

// File: hw/rtl/tkfh_ctrl.sv
// controller state machine of the top-k frequency heap
`default_nettype none

module tkfh_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire tkfh_pkg::dp_stat_t st,
    output tkfh_pkg::dp_cmd_t      cmd
);
    import tkfh_pkg::*;

    state_t  state_reg, state_next;
    status_t kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= ST_DROPPED;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.code   = kind_reg;
        busy       = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (st.is_read)
                    begin
                        if (st.rd_ok)
                        begin
                            kind_next  = ST_READ_OK;
                            state_next = S_RD;
                        end
                        else
                        begin
                            kind_next  = ST_READ_EMPTY;
                            state_next = S_OUT;
                        end
                    end
                    else if (st.ins_free)
                    begin
                        cmd.grow   = 1'b1;
                        kind_next  = ST_INSERTED;
                        state_next = S_UP_RD;
                    end
                    else if (st.ins_repl)
                    begin
                        kind_next  = ST_REPLACED;
                        state_next = S_DN_RD;
                    end
                    else
                    begin
                        kind_next  = ST_DROPPED;
                        state_next = S_OUT;
                    end
                end
            end
            S_UP_RD:
            begin
                if (st.up_top)
                begin
                    cmd.wr_item = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.up_rd  = 1'b1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (st.up_move)
                begin
                    cmd.up_step = 1'b1;
                    state_next  = S_UP_RD;
                end
                else
                begin
                    cmd.wr_item = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_DN_RD:
            begin
                cmd.dn_rd  = 1'b1;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (st.dn_move)
                begin
                    cmd.dn_step = 1'b1;
                    state_next  = S_DN_RD;
                end
                else
                begin
                    cmd.wr_item = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_RD:
            begin
                cmd.rd_slot = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/tkfh_dp.sv
// heap memory, sift datapath and result registers of the top-k frequency heap
`default_nettype none
`include "assert_macros.svh"

module tkfh_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tkfh_pkg::dp_cmd_t  cmd,
    output tkfh_pkg::dp_stat_t      st,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [4:0]         cfg_data,
    input  wire logic               action,
    input  wire logic [15:0]        word_tag,
    input  wire logic [31:0]        frequency,
    input  wire logic [3:0]         slot_index,
    output logic                    done,
    output logic [2:0]              status,
    output logic [4:0]              entry_count,
    output logic [15:0]             read_tag,
    output logic [31:0]             read_frequency,
    output logic [31:0]             min_frequency
);
    import tkfh_pkg::*;

    entry_t mem [DEPTH];

    logic [4:0]    cap_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] pos_reg;
    logic [3:0]    slot_reg;
    entry_t        item_reg;
    entry_t        rda_reg;
    entry_t        rdb_reg;
    logic [31:0]   root_reg;

    logic          done_reg;
    status_t       status_reg;
    logic [CW-1:0] count_out_reg;
    entry_t        read_out_reg;
    logic [31:0]   min_out_reg;

    logic [CW-1:0] cap_eff;
    logic [AW-1:0] parent;
    logic [KW-1:0] left_idx;
    logic [KW-1:0] right_idx;
    logic          l_ok;
    logic          r_ok;
    logic          take_r;
    entry_t        child;
    logic [KW-1:0] child_idx;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic          rd_en;
    logic          we;
    entry_t        wdata;

    assign cfg_ready = 1'b1;
    assign cap_eff   = (32'(cap_reg) > DEPTH) ? CW'(DEPTH) : CW'(cap_reg);

    assign parent    = AW'((pos_reg - AW'(1)) >> 1);
    assign left_idx  = KW'({pos_reg, 1'b1});
    assign right_idx = KW'({pos_reg, 1'b0}) + KW'(2);
    assign l_ok      = left_idx < KW'(count_reg);
    assign r_ok      = right_idx < KW'(count_reg);
    assign take_r    = r_ok && (rdb_reg.freq < rda_reg.freq);
    assign child     = take_r ? rdb_reg : rda_reg;
    assign child_idx = take_r ? right_idx : left_idx;

    always_comb
    begin
        st.is_read  = action;
        st.rd_ok    = 32'(slot_index) < 32'(count_reg);
        st.ins_free = (cap_eff != '0) && (count_reg < cap_eff);
        st.ins_repl = (cap_eff != '0) && (count_reg >= cap_eff) && (count_reg != '0)
                      && (frequency > root_reg);
        st.up_top   = (pos_reg == '0);
        st.up_move  = rda_reg.freq > item_reg.freq;
        st.dn_move  = l_ok && (child.freq < item_reg.freq);
    end

    always_comb
    begin
        addr_a = parent;
        addr_b = parent;
        if (cmd.dn_rd)
        begin
            addr_a = left_idx[AW-1:0];
            addr_b = right_idx[AW-1:0];
        end
        else if (cmd.rd_slot)
        begin
            addr_a = AW'(slot_reg);
        end
        rd_en = cmd.up_rd | cmd.dn_rd | cmd.rd_slot;
        we    = cmd.up_step | cmd.dn_step | cmd.wr_item;
        if (cmd.wr_item)
            wdata = item_reg;
        else if (cmd.up_step)
            wdata = rda_reg;
        else
            wdata = child;
    end

    // heap store
    always_ff @(posedge clk)
    begin
        if (we)
            mem[pos_reg] <= wdata;
        if (rd_en)
        begin
            rda_reg <= mem[addr_a];
            rdb_reg <= mem[addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            if (cmd.grow)
                count_reg <= count_reg + CW'(1);
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg.tag  <= word_tag;
            item_reg.freq <= frequency;
            slot_reg      <= slot_index;
            pos_reg       <= cmd.grow ? count_reg[AW-1:0] : '0;
        end
        else if (cmd.up_step)
        begin
            pos_reg <= parent;
        end
        else if (cmd.dn_step)
        begin
            pos_reg <= child_idx[AW-1:0];
        end
        if (we && (pos_reg == '0))
            root_reg <= wdata.freq;
        if (cmd.finish)
        begin
            status_reg    <= cmd.code;
            count_out_reg <= count_reg;
            read_out_reg  <= (cmd.code == ST_READ_OK) ? rda_reg : '0;
            min_out_reg   <= (count_reg != '0) ? root_reg : '0;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign entry_count    = 5'(count_out_reg);
    assign read_tag       = read_out_reg.tag;
    assign read_frequency = read_out_reg.freq;
    assign min_frequency  = min_out_reg;

    `AST_HOLD(a_count_bound, clk, rst_n, 32'(count_reg) <= DEPTH)
    `AST_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg)
    `AST_SAME(a_up_not_root, clk, rst_n, cmd.up_step, pos_reg != '0)
    `AST_SAME(a_dn_in_heap, clk, rst_n, cmd.dn_step, child_idx < KW'(count_reg))

endmodule

`default_nettype wire
